[src/bis_pkg.sv]
`default_nettype none
package bis_pkg;

    localparam int MAX_ROWS   = 256;
    localparam int MAX_COLS   = 256;
    localparam int FRAC_BITS  = 8;
    localparam int ADDR_W     = 16;
    localparam int PIX_W      = 16;
    localparam int COORD_W    = 17;
    localparam int SIZE_W     = 9;
    localparam int FILL_W     = 17;
    localparam int SAMPLE_W   = 25;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;
    localparam int WGT_W      = FRAC_BITS + 1;
    localparam int PROD_W     = PIX_W + WGT_W;
    localparam int ACC_W      = PROD_W + 1 + WGT_W + 1;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_VALUE = 2'd2;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef struct packed {
        logic                 valid;
        logic                 in_region;
        logic                 last;
        logic [FRAC_BITS-1:0] fr;
        logic [FRAC_BITS-1:0] fc;
        logic                 swap_a;
        logic                 swap_b;
    } bis_ctrl_t;

endpackage
`default_nettype wire

[src/bis_if.sv]
`default_nettype none
interface bis_in_if;
    logic                         valid;
    logic                         ready;
    logic                         opcode;
    logic [bis_pkg::ADDR_W-1:0]   pixel_address;
    logic [bis_pkg::PIX_W-1:0]    pixel_value;
    logic signed [bis_pkg::COORD_W-1:0] coord_row;
    logic signed [bis_pkg::COORD_W-1:0] coord_col;
    logic                         sample_last;
    modport source (output valid, opcode, pixel_address, pixel_value, coord_row,
                    coord_col, sample_last, input ready);
    modport sink (input valid, opcode, pixel_address, pixel_value, coord_row,
                  coord_col, sample_last, output ready);
endinterface

interface bis_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [bis_pkg::SAMPLE_W-1:0] sample_value;
    logic                                inside_res;
    logic                                result_last;
    modport source (output valid, sample_value, inside_res, result_last, input ready);
    modport sink (input valid, sample_value, inside_res, result_last, output ready);
endinterface
`default_nettype wire

[src/bilinear_image_sampler.sv]
`default_nettype none
// Bilinear image sampler. Write requests (opcode 0) store one pixel in a
// column-major image held in two parity banks, each 32K x 16 with two read
// ports, so the four neighbors of a sample are fetched together. One request
// is taken every cycle while the output is not stalled; a sample result is
// presented after its request passes the bank read, the weight multiply and
// the blend into the output register, and write requests give no result. A
// stalled output holds the whole pipeline. Configuration must be written by the
// user only while the block is idle; the block itself does not enforce this.
module bilinear_image_sampler (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    bis_in_if.sink                                in_ch,
    bis_out_if.source                             out_ch,
    input  wire logic                             cfg_we,
    input  wire logic [bis_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bis_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import bis_pkg::*;

    logic [SIZE_W-1:0]        num_rows_reg, num_cols_reg;
    logic signed [FILL_W-1:0] fill_value_reg;
    logic [SIZE_W-1:0]        rows, cols;
    logic                     en, acc_in, we;
    logic signed [SIZE_W:0]   ir, ic;
    logic                     in_region;
    logic [ADDR_W-1:0]        base, pb, pa1, pb1;
    logic [ADDR_W-2:0]        ea, eb;
    logic [PIX_W-1:0]         even_a, odd_a, even_b, odd_b;
    bis_ctrl_t                ctrl_reg, ctrl_next;
    logic                     out_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg   <= SIZE_W'(256);
            num_cols_reg   <= SIZE_W'(256);
            fill_value_reg <= -FILL_W'(65535);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_NUM_ROWS:   num_rows_reg   <= cfg_data[SIZE_W-1:0];
                CFG_NUM_COLS:   num_cols_reg   <= cfg_data[SIZE_W-1:0];
                CFG_FILL_VALUE: fill_value_reg <= cfg_data[FILL_W-1:0];
                default: ;
            endcase
        end
    end

    assign en     = !out_valid || out_ch.ready;
    assign acc_in = in_ch.valid && en;
    assign we     = acc_in && (in_ch.opcode == OP_WRITE);
    assign in_ch.ready = en;

    always_comb
    begin
        rows = num_rows_reg;
        if (num_rows_reg < SIZE_W'(2))
        begin
            rows = SIZE_W'(2);
        end
        else if (num_rows_reg > SIZE_W'(MAX_ROWS))
        begin
            rows = SIZE_W'(MAX_ROWS);
        end
        cols = num_cols_reg;
        if (num_cols_reg < SIZE_W'(2))
        begin
            cols = SIZE_W'(2);
        end
        else if (num_cols_reg > SIZE_W'(MAX_COLS))
        begin
            cols = SIZE_W'(MAX_COLS);
        end
        ir = (SIZE_W+1)'($signed(in_ch.coord_row[COORD_W-1:FRAC_BITS]));
        ic = (SIZE_W+1)'($signed(in_ch.coord_col[COORD_W-1:FRAC_BITS]));
        in_region = (ir >= $signed((SIZE_W+1)'(2)))
                 && (ir <= $signed({1'b0, rows}) - $signed((SIZE_W+1)'(1)))
                 && (ic >= $signed((SIZE_W+1)'(2)))
                 && (ic <= $signed({1'b0, cols}) - $signed((SIZE_W+1)'(1)));
        base = ADDR_W'(ir - (SIZE_W+1)'(1))
             + ADDR_W'(ADDR_W'(ic - (SIZE_W+1)'(1)) * ADDR_W'(rows));
        pb   = base + ADDR_W'(rows);
        pa1  = base + ADDR_W'(1);
        pb1  = pb + ADDR_W'(1);
        ea   = base[0] ? pa1[ADDR_W-1:1] : base[ADDR_W-1:1];
        eb   = pb[0]   ? pb1[ADDR_W-1:1] : pb[ADDR_W-1:1];
        ctrl_next.valid     = in_ch.valid && (in_ch.opcode == OP_SAMPLE);
        ctrl_next.in_region = in_region;
        ctrl_next.last      = in_ch.sample_last;
        ctrl_next.fr        = in_ch.coord_row[FRAC_BITS-1:0];
        ctrl_next.fc        = in_ch.coord_col[FRAC_BITS-1:0];
        ctrl_next.swap_a    = base[0];
        ctrl_next.swap_b    = pb[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else if (en)
        begin
            ctrl_reg <= ctrl_next;
        end
    end

    bis_bank u_even (
        .clk     (clk),
        .en      (en),
        .we      (we && !in_ch.pixel_address[0]),
        .waddr   (in_ch.pixel_address[ADDR_W-1:1]),
        .wdata   (in_ch.pixel_value),
        .raddr_a (ea),
        .raddr_b (eb),
        .rdata_a (even_a),
        .rdata_b (even_b)
    );

    bis_bank u_odd (
        .clk     (clk),
        .en      (en),
        .we      (we && in_ch.pixel_address[0]),
        .waddr   (in_ch.pixel_address[ADDR_W-1:1]),
        .wdata   (in_ch.pixel_value),
        .raddr_a (base[ADDR_W-1:1]),
        .raddr_b (pb[ADDR_W-1:1]),
        .rdata_a (odd_a),
        .rdata_b (odd_b)
    );

    bis_blend u_blend (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .ctrl       (ctrl_reg),
        .even_a     (even_a),
        .odd_a      (odd_a),
        .even_b     (even_b),
        .odd_b      (odd_b),
        .fill_value (fill_value_reg),
        .out_valid  (out_valid),
        .out_value  (out_ch.sample_value),
        .out_inside (out_ch.inside_res),
        .out_last   (out_ch.result_last)
    );

    assign out_ch.valid = out_valid;
endmodule
`default_nettype wire

[src/bis_bank.sv]
`default_nettype none
module bis_bank (
    input  wire logic                         clk,
    input  wire logic                         en,
    input  wire logic                         we,
    input  wire logic [bis_pkg::ADDR_W-2:0]   waddr,
    input  wire logic [bis_pkg::PIX_W-1:0]    wdata,
    input  wire logic [bis_pkg::ADDR_W-2:0]   raddr_a,
    input  wire logic [bis_pkg::ADDR_W-2:0]   raddr_b,
    output logic      [bis_pkg::PIX_W-1:0]    rdata_a,
    output logic      [bis_pkg::PIX_W-1:0]    rdata_b
);
    import bis_pkg::*;

    logic [PIX_W-1:0] mem [0:(1 << (ADDR_W-1))-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (en)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end
endmodule
`default_nettype wire

[src/bis_blend.sv]
`default_nettype none
module bis_blend (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      en,
    input  wire bis_pkg::bis_ctrl_t        ctrl,
    input  wire logic [bis_pkg::PIX_W-1:0] even_a,
    input  wire logic [bis_pkg::PIX_W-1:0] odd_a,
    input  wire logic [bis_pkg::PIX_W-1:0] even_b,
    input  wire logic [bis_pkg::PIX_W-1:0] odd_b,
    input  wire logic signed [bis_pkg::FILL_W-1:0] fill_value,
    output logic                           out_valid,
    output logic [bis_pkg::SAMPLE_W-1:0]   out_value,
    output logic                           out_inside,
    output logic                           out_last
);
    import bis_pkg::*;

    logic [PIX_W-1:0]     p00, p10, p01, p11;
    logic [WGT_W-1:0]     wr0, wr1, wc0_reg, wc1_reg;
    logic [PROD_W-1:0]    m00_reg, m10_reg, m01_reg, m11_reg;
    logic                 v2_reg, in2_reg, last2_reg;
    logic [ACC_W-1:0]     acc;
    logic [SAMPLE_W-1:0]  val_reg;
    logic                 v3_reg, in3_reg, last3_reg;

    always_comb
    begin
        p00 = ctrl.swap_a ? odd_a  : even_a;
        p10 = ctrl.swap_a ? even_a : odd_a;
        p01 = ctrl.swap_b ? odd_b  : even_b;
        p11 = ctrl.swap_b ? even_b : odd_b;
        wr0 = WGT_W'(1 << FRAC_BITS) - WGT_W'(ctrl.fr);
        wr1 = WGT_W'(ctrl.fr);
        acc = ACC_W'((PROD_W+1)'(m00_reg) + (PROD_W+1)'(m10_reg)) * ACC_W'(wc0_reg)
            + ACC_W'((PROD_W+1)'(m01_reg) + (PROD_W+1)'(m11_reg)) * ACC_W'(wc1_reg)
            + ACC_W'(1 << (FRAC_BITS-1));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m00_reg   <= PROD_W'(p00) * PROD_W'(wr0);
            m10_reg   <= PROD_W'(p10) * PROD_W'(wr1);
            m01_reg   <= PROD_W'(p01) * PROD_W'(wr0);
            m11_reg   <= PROD_W'(p11) * PROD_W'(wr1);
            wc0_reg   <= WGT_W'(1 << FRAC_BITS) - WGT_W'(ctrl.fc);
            wc1_reg   <= WGT_W'(ctrl.fc);
            in2_reg   <= ctrl.in_region;
            last2_reg <= ctrl.last;
            in3_reg   <= in2_reg;
            last3_reg <= last2_reg;
            if (in2_reg)
            begin
                val_reg <= acc[FRAC_BITS +: SAMPLE_W];
            end
            else
            begin
                val_reg <= {fill_value, {FRAC_BITS{1'b0}}};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= ctrl.valid;
            v3_reg <= v2_reg;
        end
    end

    assign out_valid  = v3_reg;
    assign out_value  = val_reg;
    assign out_inside = in3_reg;
    assign out_last   = last3_reg;
endmodule
`default_nettype wire

[bench/bilinear_image_sampler_test.sv]
`default_nettype none
module bilinear_image_sampler_test;
    import bis_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 12;

    typedef struct {
        logic signed [SAMPLE_W-1:0] value;
        logic                       in_region;
        logic                       last;
    } sample_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_NUM_ROWS;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    bis_in_if in_ch();
    bis_out_if out_ch();

    bilinear_image_sampler dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch.sink),
        .out_ch(out_ch.source),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    logic [PIX_W-1:0] image_px [0:(1<<ADDR_W)-1];
    int unsigned img_rows = MAX_ROWS;
    int unsigned img_cols = MAX_COLS;
    int fill_level = -65535;
    sample_t pending_samples[$];
    int mismatches = 0;
    int cycles = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.opcode = OP_WRITE;
        in_ch.pixel_address = '0;
        in_ch.pixel_value = '0;
        in_ch.coord_row = '0;
        in_ch.coord_col = '0;
        in_ch.sample_last = 1'b0;
        out_ch.ready = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(negedge clk)
        if (rst_n)
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

    // blend of the four neighbors, or the fill level outside the valid region
    function automatic sample_t predict_sample(logic signed [COORD_W-1:0] cr,
                                               logic signed [COORD_W-1:0] cc,
                                               logic last);
        sample_t s;
        int ir, ic;
        longint unsigned fr, fc, acc;
        int unsigned base;
        ir = int'(cr) >>> FRAC_BITS;
        ic = int'(cc) >>> FRAC_BITS;
        fr = cr[FRAC_BITS-1:0];
        fc = cc[FRAC_BITS-1:0];
        s.last = last;
        s.in_region = (ir >= 2 && ir <= int'(img_rows) - 1 && ic >= 2
                       && ic <= int'(img_cols) - 1);
        if (s.in_region)
        begin
            base = (ir - 1) + (ic - 1) * img_rows;
            acc = image_px[16'(base)] * (256 - fr) * (256 - fc)
                + image_px[16'(base + 1)] * fr * (256 - fc)
                + image_px[16'(base + img_rows)] * (256 - fr) * fc
                + image_px[16'(base + img_rows + 1)] * fr * fc;
            s.value = SAMPLE_W'((acc + (1 << (FRAC_BITS - 1))) >> FRAC_BITS);
        end
        else
            s.value = SAMPLE_W'(longint'(fill_level) * (1 << FRAC_BITS));
        return s;
    endfunction

    always @(posedge clk)
    begin
        sample_t exp_s;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_samples.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result value=%0d inside=%0b last=%0b",
                             out_ch.sample_value, out_ch.inside_res, out_ch.result_last);
            end
            else
            begin
                exp_s = pending_samples.pop_front();
                if (out_ch.sample_value !== exp_s.value
                    || out_ch.inside_res !== exp_s.in_region
                    || out_ch.result_last !== exp_s.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp value=%0d inside=%0b last=%0b, got %0d %0b %0b",
                                 exp_s.value, exp_s.in_region, exp_s.last, out_ch.sample_value,
                                 out_ch.inside_res, out_ch.result_last);
                end
            end
        end
    end

    task automatic send_req(logic op, logic [ADDR_W-1:0] addr, logic [PIX_W-1:0] pix,
                            logic signed [COORD_W-1:0] cr, logic signed [COORD_W-1:0] cc,
                            logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid = 1'b0;
            in_ch.opcode = 1'($urandom);
            in_ch.pixel_address = 16'($urandom);
            @(negedge clk);
        end
        in_ch.valid = 1'b1;
        in_ch.opcode = op;
        in_ch.pixel_address = addr;
        in_ch.pixel_value = pix;
        in_ch.coord_row = cr;
        in_ch.coord_col = cc;
        in_ch.sample_last = last;
        do
            @(posedge clk);
        while (!in_ch.ready);
        if (op == OP_WRITE)
            image_px[addr] = pix;
        else
            pending_samples.push_back(predict_sample(cr, cc, last));
        @(negedge clk);
    endtask

    task automatic write_px(logic [ADDR_W-1:0] addr, logic [PIX_W-1:0] pix);
        send_req(OP_WRITE, addr, pix, COORD_W'($urandom), COORD_W'($urandom), 1'($urandom));
    endtask

    task automatic sample_at(int cr, int cc, logic last);
        send_req(OP_SAMPLE, 16'($urandom), 16'($urandom), COORD_W'(cr), COORD_W'(cc), last);
    endtask

    task automatic drain;
        in_ch.valid = 1'b0;
        wait (pending_samples.size() == 0);
        @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            CFG_NUM_ROWS: img_rows = (data[8:0] < 2) ? 2 : (data[8:0] > MAX_ROWS) ? MAX_ROWS : data[8:0];
            CFG_NUM_COLS: img_cols = (data[8:0] < 2) ? 2 : (data[8:0] > MAX_COLS) ? MAX_COLS : data[8:0];
            default: fill_level = int'($signed(data[FILL_W-1:0]));
        endcase
    endtask

    task automatic set_geometry(int rows_raw, int cols_raw, int fill);
        drain();
        write_cfg(CFG_NUM_ROWS, CFG_DATA_W'(rows_raw));
        write_cfg(CFG_NUM_COLS, CFG_DATA_W'(cols_raw));
        write_cfg(CFG_FILL_VALUE, CFG_DATA_W'(fill));
    endtask

    task automatic load_image;
        for (int a = 0; a < img_rows * img_cols; a++)
            write_px(16'(a), 16'($urandom));
    endtask

    task automatic random_traffic(int n_ops);
        int r;
        for (int i = 0; i < n_ops; i++)
        begin
            r = $urandom_range(99);
            if (r < 8)
                write_px(16'($urandom), 16'($urandom));
            else if (r < 20)
                write_px(16'($urandom_range(img_rows * img_cols - 1)), 16'($urandom));
            else if (r < 40)
                sample_at(int'($urandom), int'($urandom), 1'($urandom));
            else
                sample_at($urandom_range(img_rows * 256 + 255, 256),
                          $urandom_range(img_cols * 256 + 255, 256), 1'($urandom));
        end
    endtask

    // nothing written yet: only coordinates outside the region
    task automatic test_outside_at_reset;
        sample_at(-65536, 0, 1'b1);
        sample_at(65535, 256, 1'b0);
        sample_at(511, 512, 1'b1);
        sample_at(0, 65535, 1'b0);
        sample_at(-1, -1, 1'b1);
    endtask

    task automatic test_corners;
        set_geometry(4, 5, 65535);
        for (int a = 0; a < 20; a++)
            write_px(16'(a), (a % 3 == 0) ? 16'hffff : (a % 3 == 1) ? 16'h0000 : 16'($urandom));
        sample_at(512, 512, 1'b0);
        sample_at(3 * 256 + 255, 4 * 256 + 255, 1'b1);
        sample_at(4 * 256, 512, 1'b0);
        sample_at(512, 5 * 256, 1'b1);
        sample_at(511, 768, 1'b0);
        sample_at(640, 896, 1'b1);
        sample_at(3 * 256 + 128, 2 * 256 + 1, 1'b0);
        set_geometry(4, 5, -65535);
        sample_at(0, 0, 1'b1);
    endtask

    task automatic test_clamped_sizes;
        set_geometry(1, 511, 0);
        random_traffic(100);
        set_geometry(0, 300, -1);
        random_traffic(40);
    endtask

    task automatic test_random_blend;
        set_geometry(16, 16, -1);
        load_image();
        random_traffic(130);
        drain();
        send_idle_pct = 66;
        recv_idle_pct = 21;
        set_geometry(300, 3, int'($urandom_range(131071)) - 65536);
        load_image();
        random_traffic(100);
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_geometry(9, 7, 65535);
        load_image();
        random_traffic(100);
        set_geometry(3, 100, -65535);
        load_image();
        random_traffic(60);
    endtask

    initial
    begin
        send_idle_pct = 21;
        recv_idle_pct = 66;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_outside_at_reset();
        test_corners();
        test_clamped_sizes();
        test_random_blend();
        drain();
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
`default_nettype wire
